[rtl/dlefr_pkg.sv]
// ----------------------------------------------------------------------------
// dlefr_pkg
// Shared constants, types and CRC helpers for the DLE frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dlefr_pkg;

  localparam int unsigned BUFFER_DEPTH_DEFAULT = 64;

  localparam logic [7:0]  BYTE_DLE   = 8'h10;
  localparam logic [7:0]  BYTE_STX   = 8'h02;
  localparam logic [7:0]  BYTE_ETX   = 8'h03;
  localparam logic [15:0] CRC_POLY   = 16'h8005;
  localparam logic [15:0] CRC_MSB    = 16'h8000;
  localparam logic [15:0] CRC_INIT   = 16'h0000;
  localparam int unsigned HDR_BYTES  = 4;
  localparam logic [3:0]  NODE_FIRST = 4'h1;
  localparam logic [3:0]  NODE_LAST  = 4'h8;
  localparam int unsigned LEN_MAX    = 127;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_REFLECT_CRC  = 2'd0,
    CFG_NODE_ID      = 2'd1,
    CFG_CODE_LED_ON  = 2'd2,
    CFG_CODE_LED_OFF = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    VERD_SHORT      = 3'd0,
    VERD_CRC_ERROR  = 3'd1,
    VERD_NOT_ADDR   = 3'd2,
    VERD_LED_ON     = 3'd3,
    VERD_LED_OFF    = 3'd4,
    VERD_UNKNOWN    = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_ACK  = 2'd1,
    REPLY_NACK = 2'd2
  } reply_t;

  typedef struct packed {
    verdict_t    verdict;
    reply_t      reply_kind;
    logic [7:0]  dest_mask;
    logic [7:0]  command_byte;
    logic [6:0]  frame_length;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
    logic        led_state;
  } result_t;

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [15:0] bit_rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15-i];
    end
    return r;
  endfunction

  // one byte of MSB-first CRC-16 update
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/dlefr_crc16.sv]
// ----------------------------------------------------------------------------
// dlefr_crc16
// CRC-16 (poly 0x8005, init 0) over two header bytes, optional reflection.
// ----------------------------------------------------------------------------
`default_nettype none

module dlefr_crc16 (
  input  wire logic        reflect,
  input  wire logic [7:0]  byte0,
  input  wire logic [7:0]  byte1,
  output logic      [15:0] crc
);

  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [15:0] crc_raw;

  always_comb begin
    b0      = reflect ? dlefr_pkg::bit_rev8(byte0) : byte0;
    b1      = reflect ? dlefr_pkg::bit_rev8(byte1) : byte1;
    crc_raw = dlefr_pkg::crc_byte(dlefr_pkg::crc_byte(dlefr_pkg::CRC_INIT, b0), b1);
    crc     = reflect ? dlefr_pkg::bit_rev16(crc_raw) : crc_raw;
  end

endmodule

`default_nettype wire

[rtl/dle_frame_receiver_crc_check.sv]
// ----------------------------------------------------------------------------
// dle_frame_receiver_crc_check
// DLE-STX / DLE-ETX deframer with header capture, CRC-16 check and verdict.
// ----------------------------------------------------------------------------
// Input channel: one received byte per transfer (in_valid / in_stall, rx_data).
// Output channel: one verdict per closing DLE-ETX (out_valid / out_stall);
// every other byte gives no result.
// Each byte updates the framing state in the cycle it is taken; the verdict for
// DLE-ETX is computed from the stored header in that same cycle and registered
// in the output register, or in the skid stage while that holds an untaken one.
// Throughput: one byte per cycle while in_stall is low. The output register is
// backed by a one-entry skid stage, so bytes keep flowing while a verdict
// waits; in_stall rises only when both hold a verdict. The user must write the
// configuration (cfg_wr_en / cfg_index / cfg_data) only while idle; unenforced.
// Reset: hunting for DLE-STX, LED off, no verdict pending, registers at
// reflect_crc 0, node_id 1, code_led_on 1, code_led_off 2.
// ----------------------------------------------------------------------------
`default_nettype none

module dle_frame_receiver_crc_check #(
  parameter int unsigned BUFFER_DEPTH = dlefr_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_data,
  // verdict output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [2:0]  verdict,
  output logic      [1:0]  reply_kind,
  output logic      [7:0]  dest_mask,
  output logic      [7:0]  command_byte,
  output logic      [6:0]  frame_length,
  output logic      [15:0] received_crc,
  output logic      [15:0] computed_crc,
  output logic             led_state,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned LEN_W = (CNT_W > 7) ? CNT_W : 7;

  // configuration registers
  logic       reflect_crc;
  logic [3:0] node_id;
  logic [7:0] code_led_on;
  logic [7:0] code_led_off;

  // framing state
  logic             in_frame, in_frame_next;
  logic             escape_pending, escape_pending_next;
  logic [CNT_W-1:0] payload_count, payload_count_next;
  logic [7:0]       header_store [dlefr_pkg::HDR_BYTES];
  logic             led_on, led_on_next;

  // output stage
  dlefr_pkg::result_t out_res, skid_res, fin_res;
  logic               skid_valid;

  logic        in_accept, out_fire, produce, store, hdr_we;
  logic [15:0] crc_calc;
  logic [15:0] rcrc;
  logic [2:0]  node_bit;
  logic        addressed;
  logic [LEN_W-1:0] cnt_ext;
  logic [6:0]  len_sat;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  // ---------------- verdict for the frame being closed ----------------
  dlefr_crc16 u_crc (
    .reflect (reflect_crc),
    .byte0   (header_store[0]),
    .byte1   (header_store[1]),
    .crc     (crc_calc)
  );

  always_comb begin
    rcrc      = {header_store[2], header_store[3]};
    node_bit  = 3'(node_id - dlefr_pkg::NODE_FIRST);
    addressed = (node_id >= dlefr_pkg::NODE_FIRST) && (node_id <= dlefr_pkg::NODE_LAST) &&
                header_store[0][node_bit];
    cnt_ext   = LEN_W'(payload_count);
    len_sat   = (cnt_ext > LEN_W'(dlefr_pkg::LEN_MAX)) ? 7'(dlefr_pkg::LEN_MAX) : cnt_ext[6:0];

    fin_res              = '0;
    fin_res.verdict      = dlefr_pkg::VERD_SHORT;
    fin_res.reply_kind   = dlefr_pkg::REPLY_NONE;
    fin_res.frame_length = len_sat;
    led_on_next          = led_on;
    if (payload_count >= CNT_W'(dlefr_pkg::HDR_BYTES)) begin
      fin_res.dest_mask    = header_store[0];
      fin_res.command_byte = header_store[1];
      fin_res.received_crc = rcrc;
      fin_res.computed_crc = crc_calc;
      if (rcrc != crc_calc) begin
        fin_res.verdict    = dlefr_pkg::VERD_CRC_ERROR;
        fin_res.reply_kind = dlefr_pkg::REPLY_NACK;
      end else if (addressed) begin
        if (header_store[1] == code_led_on) begin
          led_on_next        = 1'b1;
          fin_res.verdict    = dlefr_pkg::VERD_LED_ON;
          fin_res.reply_kind = dlefr_pkg::REPLY_ACK;
        end else if (header_store[1] == code_led_off) begin
          led_on_next        = 1'b0;
          fin_res.verdict    = dlefr_pkg::VERD_LED_OFF;
          fin_res.reply_kind = dlefr_pkg::REPLY_ACK;
        end else begin
          fin_res.verdict    = dlefr_pkg::VERD_UNKNOWN;
        end
      end else begin
        fin_res.verdict = dlefr_pkg::VERD_NOT_ADDR;
      end
    end
    fin_res.led_state = led_on_next;
  end

  // ---------------- byte-level deframing ----------------
  always_comb begin
    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    payload_count_next  = payload_count;
    produce             = 1'b0;
    store               = 1'b0;
    hdr_we              = 1'b0;
    if (in_accept) begin
      if (!in_frame) begin
        // hunting: only DLE STX opens a frame
        if (escape_pending && rx_data == dlefr_pkg::BYTE_STX) begin
          in_frame_next       = 1'b1;
          escape_pending_next = 1'b0;
          payload_count_next  = '0;
        end else begin
          escape_pending_next = (rx_data == dlefr_pkg::BYTE_DLE);
        end
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (rx_data == dlefr_pkg::BYTE_ETX) begin
          produce            = 1'b1;
          in_frame_next      = 1'b0;
          payload_count_next = '0;
        end else if (rx_data == dlefr_pkg::BYTE_DLE) begin
          store = 1'b1;
        end
      end else if (rx_data == dlefr_pkg::BYTE_DLE) begin
        escape_pending_next = 1'b1;
      end else begin
        store = 1'b1;
      end
    end
    if (store && payload_count < CNT_W'(BUFFER_DEPTH)) begin
      payload_count_next = payload_count + CNT_W'(1);
      hdr_we             = (payload_count < CNT_W'(dlefr_pkg::HDR_BYTES));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reflect_crc    <= 1'b0;
      node_id        <= 4'd1;
      code_led_on    <= 8'd1;
      code_led_off   <= 8'd2;
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      payload_count  <= '0;
      led_on         <= 1'b0;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (dlefr_pkg::cfg_index_t'(cfg_index))
          dlefr_pkg::CFG_REFLECT_CRC:  reflect_crc  <= cfg_data[0];
          dlefr_pkg::CFG_NODE_ID:      node_id      <= cfg_data[3:0];
          dlefr_pkg::CFG_CODE_LED_ON:  code_led_on  <= cfg_data;
          dlefr_pkg::CFG_CODE_LED_OFF: code_led_off <= cfg_data;
          default: ;
        endcase
      end
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      payload_count  <= payload_count_next;
      if (produce) begin
        led_on <= led_on_next;
      end
      if (skid_valid) begin
        if (out_fire) begin
          skid_valid <= 1'b0;
        end
      end else if (produce) begin
        if (out_valid && !out_fire) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and verdict registers
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      header_store[payload_count[1:0]] <= rx_data;
    end
    if (skid_valid) begin
      if (out_fire) begin
        out_res <= skid_res;
      end
    end else if (produce) begin
      if (out_valid && !out_fire) begin
        skid_res <= fin_res;
      end else begin
        out_res <= fin_res;
      end
    end
  end

  assign verdict      = out_res.verdict;
  assign reply_kind   = out_res.reply_kind;
  assign dest_mask    = out_res.dest_mask;
  assign command_byte = out_res.command_byte;
  assign frame_length = out_res.frame_length;
  assign received_crc = out_res.received_crc;
  assign computed_crc = out_res.computed_crc;
  assign led_state    = out_res.led_state;

  // ---------------- assertions ----------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a verdict while output register is empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    payload_count <= CNT_W'(BUFFER_DEPTH))
    else $error("payload count beyond buffer depth");

  a_hunt_count_zero: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> payload_count == '0)
    else $error("payload count nonzero while hunting");

  a_led_on_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.verdict == dlefr_pkg::VERD_LED_ON |-> out_res.led_state)
    else $error("LED-on verdict without LED state set");

  a_short_no_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.verdict == dlefr_pkg::VERD_SHORT |->
      out_res.reply_kind == dlefr_pkg::REPLY_NONE && out_res.computed_crc == 16'h0000)
    else $error("short frame verdict carries reply or CRC");

endmodule

`default_nettype wire

[tb/sv/tb_dle_frame_receiver_crc_check.sv]
// ----------------------------------------------------------------------------
// tb_dle_frame_receiver_crc_check
// Self-checking bench for the DLE-STX / DLE-ETX deframer with CRC-16 verdict.
// A scoreboard class tracks the framing state of the byte stream, predicts
// one verdict for each closing DLE-ETX and checks the verdicts that come out.
// Stimulus is a short directed stream, then random frames (good, short,
// overlong, garbled, unclosed) with noise, under several register settings.
// ----------------------------------------------------------------------------

module tb_dle_frame_receiver_crc_check;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = dlefr_pkg::BUFFER_DEPTH_DEFAULT;

  class frame_verdict_board;
    logic        reflect;
    logic [3:0]  node;
    logic [7:0]  code_on;
    logic [7:0]  code_off;
    bit          in_frame;
    bit          escaped;
    bit          led;
    int unsigned count;
    logic [7:0]  header [4];
    dlefr_pkg::result_t expected_verdicts [$];
    int unsigned errors;

    function new();
      reflect  = 1'b0;
      node     = 4'd1;
      code_on  = 8'd1;
      code_off = 8'd2;
      in_frame = 0;
      escaped  = 0;
      led      = 0;
      count    = 0;
      errors   = 0;
      foreach (header[i]) header[i] = 8'h00;
    endfunction

    function void set_reg(dlefr_pkg::cfg_index_t idx, logic [7:0] val);
      case (idx)
        dlefr_pkg::CFG_REFLECT_CRC:  reflect  = val[0];
        dlefr_pkg::CFG_NODE_ID:      node     = val[3:0];
        dlefr_pkg::CFG_CODE_LED_ON:  code_on  = val;
        dlefr_pkg::CFG_CODE_LED_OFF: code_off = val;
        default: ;
      endcase
    endfunction

    // bit-serial division of the 16-bit message, MSB first, register starts at 0
    function logic [15:0] crc16_two_bytes(logic [7:0] b0, logic [7:0] b1);
      logic [15:0] msg;
      logic [15:0] rem;
      logic [15:0] flipped;
      logic        fb;
      msg = {b0, b1};
      rem = dlefr_pkg::CRC_INIT;
      if (reflect) begin
        for (int i = 0; i < 8; i++) begin
          msg[15-i] = b0[i];
          msg[7-i]  = b1[i];
        end
      end
      for (int i = 15; i >= 0; i--) begin
        fb  = rem[15] ^ msg[i];
        rem = {rem[14:0], 1'b0};
        if (fb) rem = rem ^ dlefr_pkg::CRC_POLY;
      end
      if (reflect) begin
        for (int i = 0; i < 16; i++) flipped[i] = rem[15-i];
        rem = flipped;
      end
      return rem;
    endfunction

    function void keep_payload(logic [7:0] b);
      if (count < DEPTH) begin
        if (count < dlefr_pkg::HDR_BYTES) header[count] = b;
        count++;
      end
    endfunction

    // called for every accepted input transfer
    function void take_byte(logic [7:0] b);
      dlefr_pkg::result_t v;
      if (!in_frame) begin
        if (escaped && b == dlefr_pkg::BYTE_STX) begin
          count    = 0;
          in_frame = 1;
          escaped  = 0;
        end else begin
          escaped = (b == dlefr_pkg::BYTE_DLE);
        end
      end else if (escaped) begin
        escaped = 0;
        if (b == dlefr_pkg::BYTE_ETX) begin
          v = '0;
          v.verdict      = dlefr_pkg::VERD_SHORT;
          v.reply_kind   = dlefr_pkg::REPLY_NONE;
          v.frame_length = (count > dlefr_pkg::LEN_MAX) ? 7'(dlefr_pkg::LEN_MAX) : 7'(count);
          if (count >= dlefr_pkg::HDR_BYTES) begin
            v.dest_mask    = header[0];
            v.command_byte = header[1];
            v.received_crc = {header[2], header[3]};
            v.computed_crc = crc16_two_bytes(header[0], header[1]);
            if (v.received_crc != v.computed_crc) begin
              v.verdict    = dlefr_pkg::VERD_CRC_ERROR;
              v.reply_kind = dlefr_pkg::REPLY_NACK;
            end else if (node >= dlefr_pkg::NODE_FIRST && node <= dlefr_pkg::NODE_LAST &&
                         header[0][3'(node - 4'd1)]) begin
              // LED-on code wins when both codes match
              if (header[1] == code_on) begin
                led          = 1;
                v.verdict    = dlefr_pkg::VERD_LED_ON;
                v.reply_kind = dlefr_pkg::REPLY_ACK;
              end else if (header[1] == code_off) begin
                led          = 0;
                v.verdict    = dlefr_pkg::VERD_LED_OFF;
                v.reply_kind = dlefr_pkg::REPLY_ACK;
              end else begin
                v.verdict = dlefr_pkg::VERD_UNKNOWN;
              end
            end else begin
              v.verdict = dlefr_pkg::VERD_NOT_ADDR;
            end
          end
          v.led_state = led;
          expected_verdicts.push_back(v);
          in_frame = 0;
          count    = 0;
        end else if (b == dlefr_pkg::BYTE_DLE) begin
          keep_payload(b);
        end
      end else if (b == dlefr_pkg::BYTE_DLE) begin
        escaped = 1;
      end else begin
        keep_payload(b);
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // called for every accepted output transfer
    function void check_verdict(dlefr_pkg::result_t got);
      dlefr_pkg::result_t want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict, expected none actual 0x%0h", $time, got);
        errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      check_field("verdict",      want.verdict,      got.verdict);
      check_field("reply_kind",   want.reply_kind,   got.reply_kind);
      check_field("dest_mask",    want.dest_mask,    got.dest_mask);
      check_field("command_byte", want.command_byte, got.command_byte);
      check_field("frame_length", want.frame_length, got.frame_length);
      check_field("received_crc", want.received_crc, got.received_crc);
      check_field("computed_crc", want.computed_crc, got.computed_crc);
      check_field("led_state",    want.led_state,    got.led_state);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_data   = 8'h00;
  logic        out_stall = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data  = 8'h00;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  verdict;
  logic [1:0]  reply_kind;
  logic [7:0]  dest_mask;
  logic [7:0]  command_byte;
  logic [6:0]  frame_length;
  logic [15:0] received_crc;
  logic [15:0] computed_crc;
  logic        led_state;

  frame_verdict_board sb;
  logic [7:0]         byte_stream [$];
  int                 bytes_sent      = 0;
  bit                 tx_idle_on      = 1;
  bit                 rx_idle_on      = 1;
  int                 hold_off_cycles = 0;

  dle_frame_receiver_crc_check #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_data      (rx_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .verdict      (verdict),
    .reply_kind   (reply_kind),
    .dest_mask    (dest_mask),
    .command_byte (command_byte),
    .frame_length (frame_length),
    .received_crc (received_crc),
    .computed_crc (computed_crc),
    .led_state    (led_state),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.take_byte(rx_data);
    if (!rst && out_valid && !out_stall) begin
      sb.check_verdict({verdict, reply_kind, dest_mask, command_byte, frame_length,
                        received_crc, computed_crc, led_state});
    end
  end

  // receiver side: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    forever begin
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_byte(logic [7:0] b);
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_data  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_stream();
    while (byte_stream.size() != 0) send_byte(byte_stream.pop_front());
  endtask

  // drop valid and let every pending verdict drain before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_verdicts.size() != 0 || out_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(dlefr_pkg::cfg_index_t idx, logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_config(logic reflect, logic [3:0] node, logic [7:0] on_code,
                              logic [7:0] off_code);
    write_reg(dlefr_pkg::CFG_REFLECT_CRC, {7'd0, reflect});
    write_reg(dlefr_pkg::CFG_NODE_ID, {4'd0, node});
    write_reg(dlefr_pkg::CFG_CODE_LED_ON, on_code);
    write_reg(dlefr_pkg::CFG_CODE_LED_OFF, off_code);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0:       return dlefr_pkg::BYTE_DLE;
      1:       return dlefr_pkg::BYTE_STX;
      2:       return dlefr_pkg::BYTE_ETX;
      default: return 8'($urandom);
    endcase
  endfunction

  // payload order: dest, cmd, crc hi, crc lo, filler; data DLE is doubled
  function automatic void build_frame(logic [7:0] dest, logic [7:0] cmd, logic [15:0] crc,
                                      int len, int garble_at, bit close);
    logic [7:0] b;
    byte_stream.push_back(dlefr_pkg::BYTE_DLE);
    byte_stream.push_back(dlefr_pkg::BYTE_STX);
    for (int i = 0; i < len; i++) begin
      if (i == garble_at) begin
        byte_stream.push_back(dlefr_pkg::BYTE_DLE);
        byte_stream.push_back(noise_byte());
      end
      case (i)
        0:       b = dest;
        1:       b = cmd;
        2:       b = crc[15:8];
        3:       b = crc[7:0];
        default: b = 8'($urandom);
      endcase
      byte_stream.push_back(b);
      if (b == dlefr_pkg::BYTE_DLE) byte_stream.push_back(dlefr_pkg::BYTE_DLE);
    end
    if (close) begin
      byte_stream.push_back(dlefr_pkg::BYTE_DLE);
      byte_stream.push_back(dlefr_pkg::BYTE_ETX);
    end
  endfunction

  function automatic void random_frame();
    logic [7:0]  dest;
    logic [7:0]  cmd;
    logic [15:0] crc;
    int          len;
    int          pick;
    int          garble_at;
    pick = $urandom_range(0, 99);
    if (pick < 3) len = $urandom_range(DEPTH - 4, DEPTH + 8);
    else if (pick < 15) len = $urandom_range(0, 3);
    else len = $urandom_range(4, 9);
    dest = 8'($urandom);
    if (sb.node >= dlefr_pkg::NODE_FIRST && sb.node <= dlefr_pkg::NODE_LAST &&
        $urandom_range(0, 3) != 0)
      dest[3'(sb.node - 4'd1)] = 1'b1;
    pick = $urandom_range(0, 9);
    cmd  = (pick < 4) ? sb.code_on : (pick < 7) ? sb.code_off : 8'($urandom);
    crc  = sb.crc16_two_bytes(dest, cmd);
    if ($urandom_range(0, 5) == 0) crc = 16'($urandom);
    garble_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, len)) : -1;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) byte_stream.push_back(noise_byte());
    end
    build_frame(dest, cmd, crc, len, garble_at, $urandom_range(0, 19) != 0);
  endfunction

  task automatic random_phase(int n_bytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      random_frame();
      send_stream();
    end
  endtask

  initial begin : stimulus
    logic [7:0] code;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // hunting noise, DLE DLE STX opener, data DLE, dropped escapes, short close
    byte_stream = '{8'hFF, dlefr_pkg::BYTE_DLE, dlefr_pkg::BYTE_DLE, dlefr_pkg::BYTE_STX,
                    8'h00, dlefr_pkg::BYTE_DLE, dlefr_pkg::BYTE_DLE, dlefr_pkg::BYTE_DLE,
                    8'h55, dlefr_pkg::BYTE_DLE, dlefr_pkg::BYTE_STX,
                    dlefr_pkg::BYTE_DLE, dlefr_pkg::BYTE_ETX};
    build_frame(8'h01, 8'h01, sb.crc16_two_bytes(8'h01, 8'h01), 4, -1, 1);
    send_stream();
    wait_idle();

    apply_config(1'b1, 4'd8, 8'hFF, 8'h00);
    // long receiver hold-off while header-only frames keep coming
    tx_idle_on      = 0;
    hold_off_cycles = 300;
    repeat (12) begin
      code = 8'($urandom) | 8'h80;
      build_frame(code, 8'hFF, sb.crc16_two_bytes(code, 8'hFF), 4, -1, 1);
    end
    send_stream();
    tx_idle_on = 1;
    random_phase(120);
    wait_idle();

    code = 8'($urandom);
    apply_config(1'b0, 4'($urandom_range(1, 8)), code, code);
    random_phase(120);
    wait_idle();

    apply_config(1'b1, ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15)),
                 8'($urandom), 8'($urandom));
    random_phase(100);
    wait_idle();

    tx_idle_on = 0;
    rx_idle_on = 0;
    apply_config(1'($urandom), 4'($urandom_range(1, 8)), 8'($urandom), 8'($urandom));
    random_phase(120);
    wait_idle();

    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
rtl/dlefr_pkg.sv
rtl/dlefr_crc16.sv
rtl/dle_frame_receiver_crc_check.sv
tb/sv/tb_dle_frame_receiver_crc_check.sv
